### rtl/cflru_pkg.sv
// Package for the clean-first LRU page replacement block.
// Holds default sizes, the controller state type and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cflru_pkg;

   localparam int MaxFramesDef  = 64;
   localparam int MaxHistoryDef = 32;

   // Width of the clamped capacity and window arithmetic (covers up to 511 frames).
   localparam int CapWidth = 9;
   localparam int CfgWidth = 7;

   localparam logic [CfgWidth-1:0] CfgReset   = 7'd64;
   localparam logic [CfgWidth-1:0] WindowSat  = 7'd127;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_PUSH,
      ST_START,
      ST_SCAN,
      ST_VICTIM,
      ST_UPDATE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic trim;
      logic push;
      logic start;
      logic step;
      logic read_victim;
      logic update;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic trim_needed;
      logic scan_done;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

### rtl/cflru_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cflru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/cflru_ctrl.sv
// Controller state machine of the clean-first LRU block.
// Depends on cflru_pkg; drives the datapath through cmd_type, watches status_type.
`timescale 1ns / 1ps
`default_nettype none

module cflru_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cflru_pkg::cmd_type        cmd,
   input  wire cflru_pkg::status_type status
);

   cflru_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == cflru_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cflru_pkg::ST_IDLE: begin
            if (req_valid) state_in = cflru_pkg::ST_TRIM;
         end
         cflru_pkg::ST_TRIM: begin
            if (!status.trim_needed) state_in = cflru_pkg::ST_PUSH;
         end
         cflru_pkg::ST_PUSH:   state_in = cflru_pkg::ST_START;
         cflru_pkg::ST_START:  state_in = cflru_pkg::ST_SCAN;
         cflru_pkg::ST_SCAN: begin
            if (status.scan_done && status.div_done) state_in = cflru_pkg::ST_VICTIM;
         end
         cflru_pkg::ST_VICTIM: state_in = cflru_pkg::ST_UPDATE;
         cflru_pkg::ST_UPDATE: begin
            if (status.scan_done) state_in = cflru_pkg::ST_COMMIT;
         end
         cflru_pkg::ST_COMMIT: begin
            if (out_free) state_in = cflru_pkg::ST_IDLE;
         end
         default: state_in = cflru_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         cflru_pkg::ST_IDLE:   cmd.load = req_valid;
         cflru_pkg::ST_TRIM:   cmd.trim = status.trim_needed;
         cflru_pkg::ST_PUSH:   cmd.push = 1'b1;
         cflru_pkg::ST_START:  cmd.start = 1'b1;
         cflru_pkg::ST_SCAN:   cmd.step = 1'b1;
         cflru_pkg::ST_VICTIM: cmd.read_victim = 1'b1;
         cflru_pkg::ST_UPDATE: cmd.update = 1'b1;
         cflru_pkg::ST_COMMIT: cmd.commit = out_free;
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cflru_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cflru_dp.sv
// Datapath of the clean-first LRU block: page RAM, rank and dirty RAM, access
// history, window divider, scan, rank update pass and result registers.
// Depends on cflru_pkg and cflru_ram.
`timescale 1ns / 1ps
`default_nettype none

module cflru_dp #(
   parameter int MAX_FRAMES  = cflru_pkg::MaxFramesDef,
   parameter int MAX_HISTORY = cflru_pkg::MaxHistoryDef
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cflru_pkg::cmd_type       cmd,
   output cflru_pkg::status_type         status,
   input  wire logic                     csr_wr_en,
   input  wire logic [6:0]               csr_wr_data,
   input  wire logic [31:0]              req_page_id,
   input  wire logic                     req_opcode,
   output logic                          rsp_hit,
   output logic                          rsp_fetch_needed,
   output logic                          rsp_victim_valid,
   output logic [31:0]                   rsp_victim_page,
   output logic                          rsp_victim_writeback,
   output logic [6:0]                    rsp_window_used
);

   localparam int SlotW = $clog2(MAX_FRAMES);
   localparam int OccW  = $clog2(MAX_FRAMES + 1);
   localparam int HcntW = $clog2(MAX_HISTORY + 1);
   localparam int HidxW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int ProdW = OccW + HcntW;
   localparam int DcntW = $clog2(ProdW + 1);
   localparam int CapW  = cflru_pkg::CapWidth;

   // Configuration and clamped capacity / history length.
   logic [6:0]      frames_ff;
   logic [CapW-1:0] cap, hlen_raw, hlen;

   always_comb begin
      if (frames_ff < 7'd2)                       cap = CapW'(2);
      else if (CapW'(frames_ff) > CapW'(MAX_FRAMES)) cap = CapW'(MAX_FRAMES);
      else                                        cap = CapW'(frames_ff);
      hlen_raw = cap >> 1;
      if (hlen_raw > CapW'(MAX_HISTORY)) hlen = CapW'(MAX_HISTORY);
      else if (hlen_raw == '0)           hlen = CapW'(1);
      else                               hlen = hlen_raw;
   end

   // Captured access.
   logic [31:0] page_ff;
   logic        wr_ff;

   // History: newest kind at index 0.
   logic [MAX_HISTORY-1:0] hist_ff, hist_in;
   logic [HcntW-1:0]       hcnt_ff, hwr_ff;
   logic                   oldest;

   assign oldest             = hist_ff[HidxW'(hcnt_ff - HcntW'(1))];
   assign status.trim_needed = CapW'(hcnt_ff) >= hlen;

   always_comb begin
      hist_in[0] = wr_ff;
      for (int i = 1; i < MAX_HISTORY; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
   end

   // Resident count; each slot's rank and dirty mark live in the meta RAM.
   logic [OccW-1:0]  occ_ff;

   // Window divider, restoring, one quotient bit per cycle.
   logic [ProdW-1:0] num_ff;
   logic [HcntW-1:0] rem_ff;
   logic [DcntW-1:0] dcnt_ff;
   logic [HcntW:0]   trial;
   logic             qbit;
   logic [OccW-1:0]  window;

   assign trial           = {rem_ff, num_ff[ProdW-1]};
   assign qbit            = trial >= {1'b0, hcnt_ff};
   assign status.div_done = (dcnt_ff == '0);
   assign window = (num_ff > ProdW'(occ_ff)) ? occ_ff : OccW'(num_ff);

   // Walk over resident slots, used by the lookup scan and the rank update pass.
   logic [OccW-1:0]  scan_cnt_ff;
   logic             chk_vld_ff;
   logic [SlotW-1:0] chk_slot_ff;
   logic             found_ff, hit_dirty_ff;
   logic [SlotW-1:0] hit_slot_ff, hit_rank_ff;
   logic             clean_vld_ff;
   logic [SlotW-1:0] clean_slot_ff, clean_rank_ff;
   logic [SlotW-1:0] lru_slot_ff;
   logic             lru_dirty_ff;
   logic             issue;
   logic [SlotW-1:0] chk_rank;
   logic             chk_dirty;
   logic [31:0]      ram_rdata;
   logic [SlotW:0]   meta_rdata;

   assign issue            = scan_cnt_ff < occ_ff;
   assign chk_rank         = meta_rdata[SlotW-1:0];
   assign chk_dirty        = meta_rdata[SlotW];
   assign status.scan_done = !issue && !chk_vld_ff;

   // Victim choice: the clean page nearest the LRU end wins if inside the window.
   logic             evict, use_clean;
   logic [SlotW-1:0] vslot, tslot;
   logic [OccW-1:0]  old_rank;
   logic             vdirty;
   logic             new_dirty;

   assign evict     = !found_ff && (CapW'(occ_ff) >= cap) && (occ_ff != '0);
   assign use_clean = clean_vld_ff && (OccW'(clean_rank_ff) >= (occ_ff - window));
   assign vslot     = use_clean ? clean_slot_ff : lru_slot_ff;
   assign vdirty    = use_clean ? 1'b0 : lru_dirty_ff;
   assign new_dirty = found_ff ? (hit_dirty_ff | wr_ff) : wr_ff;

   always_comb begin
      if (found_ff) begin
         tslot    = hit_slot_ff;
         old_rank = OccW'(hit_rank_ff);
      end else if (evict) begin
         tslot    = vslot;
         old_rank = use_clean ? OccW'(clean_rank_ff) : (occ_ff - OccW'(1));
      end else begin
         tslot    = SlotW'(occ_ff);
         old_rank = occ_ff;
      end
   end

   // The update pass ages every page more recent than the one that moves to the
   // front; commit then writes the front slot with rank zero.
   logic             meta_wr_en;
   logic [SlotW-1:0] meta_wr_addr;
   logic [SlotW:0]   meta_wr_data;

   always_comb begin
      meta_wr_en   = 1'b0;
      meta_wr_addr = tslot;
      meta_wr_data = {new_dirty, {SlotW{1'b0}}};
      if (cmd.commit) begin
         meta_wr_en = 1'b1;
      end else if (cmd.update && chk_vld_ff) begin
         meta_wr_en   = 1'b1;
         meta_wr_addr = chk_slot_ff;
         if (OccW'(chk_rank) < old_rank) begin
            meta_wr_data = {chk_dirty, chk_rank + SlotW'(1)};
         end else begin
            meta_wr_data = meta_rdata;
         end
      end
   end

   cflru_ram #(
      .WIDTH (32),
      .DEPTH (MAX_FRAMES)
   ) u_pages (
      .clock   (clock),
      .wr_en   (cmd.commit && !found_ff),
      .wr_addr (tslot),
      .wr_data (page_ff),
      .rd_en   ((cmd.step && issue) || cmd.read_victim),
      .rd_addr (cmd.read_victim ? vslot : scan_cnt_ff[SlotW-1:0]),
      .rd_data (ram_rdata)
   );

   cflru_ram #(
      .WIDTH (SlotW + 1),
      .DEPTH (MAX_FRAMES)
   ) u_meta (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   ((cmd.step || cmd.update) && issue),
      .rd_addr (scan_cnt_ff[SlotW-1:0]),
      .rd_data (meta_rdata)
   );

   logic [CapW-1:0] win_ext;
   assign win_ext = CapW'(window);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= cflru_pkg::CfgReset;
         hist_ff   <= '0;
         hcnt_ff   <= '0;
         hwr_ff    <= '0;
         occ_ff    <= '0;
         dcnt_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) frames_ff <= csr_wr_data;
         if (cmd.trim) begin
            hcnt_ff <= hcnt_ff - HcntW'(1);
            if (oldest) hwr_ff <= hwr_ff - HcntW'(1);
         end
         if (cmd.push) begin
            hist_ff <= hist_in;
            hcnt_ff <= hcnt_ff + HcntW'(1);
            hwr_ff  <= hwr_ff + HcntW'(wr_ff);
         end
         if (cmd.start) begin
            dcnt_ff <= DcntW'(ProdW);
         end else if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - DcntW'(1);
         end
         if (cmd.start || cmd.read_victim) chk_vld_ff <= 1'b0;
         else if (cmd.step || cmd.update) chk_vld_ff <= issue;
         if (cmd.commit && !found_ff && !evict) occ_ff <= occ_ff + OccW'(1);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_page_id;
         wr_ff   <= req_opcode;
      end
      if (cmd.start) begin
         num_ff <= ProdW'(occ_ff) * ProdW'(hwr_ff);
         rem_ff <= '0;
      end else if (dcnt_ff != '0) begin
         num_ff <= {num_ff[ProdW-2:0], qbit};
         rem_ff <= qbit ? HcntW'(trial - {1'b0, hcnt_ff}) : HcntW'(trial);
      end
      if (cmd.start || cmd.read_victim) begin
         scan_cnt_ff <= '0;
      end else if ((cmd.step || cmd.update) && issue) begin
         scan_cnt_ff <= scan_cnt_ff + OccW'(1);
         chk_slot_ff <= scan_cnt_ff[SlotW-1:0];
      end
      if (cmd.start) begin
         found_ff     <= 1'b0;
         clean_vld_ff <= 1'b0;
      end else if (cmd.step && chk_vld_ff) begin
         if (ram_rdata == page_ff && !found_ff) begin
            found_ff     <= 1'b1;
            hit_slot_ff  <= chk_slot_ff;
            hit_rank_ff  <= chk_rank;
            hit_dirty_ff <= chk_dirty;
         end
         if (!chk_dirty && (!clean_vld_ff || chk_rank > clean_rank_ff)) begin
            clean_vld_ff  <= 1'b1;
            clean_slot_ff <= chk_slot_ff;
            clean_rank_ff <= chk_rank;
         end
         if (OccW'(chk_rank) == occ_ff - OccW'(1)) begin
            lru_slot_ff  <= chk_slot_ff;
            lru_dirty_ff <= chk_dirty;
         end
      end
      if (cmd.commit) begin
         rsp_hit              <= found_ff;
         rsp_fetch_needed     <= !found_ff && !wr_ff;
         rsp_victim_valid     <= evict;
         rsp_victim_page      <= evict ? ram_rdata : 32'd0;
         rsp_victim_writeback <= evict && vdirty;
         rsp_window_used      <= (win_ext > CapW'(cflru_pkg::WindowSat)) ?
                                 cflru_pkg::WindowSat : win_ext[6:0];
      end
   end

endmodule

`default_nettype wire

### rtl/clean_first_lru_dynamic_window.sv
// Top level of the clean-first LRU page replacement block.
// Depends on cflru_pkg, cflru_ctrl and cflru_dp.
`timescale 1ns / 1ps
`default_nettype none

// Each request transfer is one page access (read or write). The block keeps the
// resident pages in recency order with their dirty marks and a history of the
// last frames_in_use/2 access kinds, and returns one response transfer per
// request: hit, fetch needed, and on a miss with a full buffer the evicted page
// and whether it must be written back. The eviction window is
// occupancy * writes_in_history / history_length; inside that many pages at the
// LRU end the first clean page is evicted, otherwise the LRU page.
// An access runs through trim, history push, start, lookup scan, victim read,
// rank update pass and commit. The window divider runs beside the scan, one
// quotient bit per cycle, and the scan waits for the divider to finish. Trim
// drops history entries one at a time: one per access once the history is
// full, more after frames_in_use is lowered. The scan and the update pass each
// visit one slot per cycle through registered-read RAMs. One access is
// processed at a time; a finished response sits in an output register, the
// next request is taken while it waits, and the following commit stalls until
// that response transfer happens. frames_in_use is to be written through the
// csr port only while the block is idle; the block itself does not enforce it.

module clean_first_lru_dynamic_window #(
   parameter int MAX_FRAMES  = cflru_pkg::MaxFramesDef,
   parameter int MAX_HISTORY = cflru_pkg::MaxHistoryDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_page_id,
   input  wire logic        req_opcode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic             rsp_fetch_needed,
   output logic             rsp_victim_valid,
   output logic [31:0]      rsp_victim_page,
   output logic             rsp_victim_writeback,
   output logic [6:0]       rsp_window_used
);

   cflru_pkg::cmd_type    cmd;
   cflru_pkg::status_type status;

   // The controller sequences trim, history push, scan, rank update and commit.
   cflru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds all page state and the response register.
   cflru_dp #(
      .MAX_FRAMES  (MAX_FRAMES),
      .MAX_HISTORY (MAX_HISTORY)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_page_id          (req_page_id),
      .req_opcode           (req_opcode),
      .rsp_hit              (rsp_hit),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_victim_valid     (rsp_victim_valid),
      .rsp_victim_page      (rsp_victim_page),
      .rsp_victim_writeback (rsp_victim_writeback),
      .rsp_window_used      (rsp_window_used)
   );

endmodule

`default_nettype wire

### rtl/cflru_checker.sv
// Port-level checker for the clean-first LRU block, bound to the top level.
// Depends on clean_first_lru_dynamic_window.
`timescale 1ns / 1ps
`default_nettype none

module cflru_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic        rsp_fetch_needed,
   input wire logic        rsp_victim_valid,
   input wire logic [31:0] rsp_victim_page,
   input wire logic        rsp_victim_writeback
);

   // A held response keeps its victim page.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_page))
      else $error("response changed while stalled");

   // One access is processed at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_victim_valid && !rsp_fetch_needed)
      else $error("hit with eviction or fetch");

   a_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_victim_valid |-> rsp_victim_page == 32'd0 && !rsp_victim_writeback)
      else $error("victim fields set without victim");

endmodule

bind clean_first_lru_dynamic_window cflru_checker u_cflru_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_hit              (rsp_hit),
   .rsp_fetch_needed     (rsp_fetch_needed),
   .rsp_victim_valid     (rsp_victim_valid),
   .rsp_victim_page      (rsp_victim_page),
   .rsp_victim_writeback (rsp_victim_writeback)
);

`default_nettype wire
